[rtl/core/sthm_pkg.sv]
// shared types and constants of the sensor timestamp health monitor
// no dependencies; every other file of the block imports this package
package sthm_pkg;

  localparam int CNT_W    = 32;
  localparam int STAMP_W  = 63;
  localparam int DELAY_W  = 48;
  localparam int DMAX_W   = 47;
  localparam int SUM_W    = 64;
  localparam int CFG_W    = 32;
  localparam int CFG_IDX_W = 2;
  localparam int FUNC_W   = 2;

  localparam logic [FUNC_W-1:0] FUNC_OBSERVE  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_WINDOW   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_LIFETIME = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_GAP_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_JITTER_WARN   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_JITTER_DEGRADE = 2'd2;

  localparam logic [CFG_W-1:0] GAP_THRESHOLD_RESET  = 32'd100000000;
  localparam logic [CFG_W-1:0] JITTER_WARN_RESET    = 32'd2000000;
  localparam logic [CFG_W-1:0] JITTER_DEGRADE_RESET = 32'd10000000;

  typedef enum logic [2:0] {
    REASON_OK          = 3'd0,
    REASON_JITTER_WARN = 3'd1,
    REASON_JITTER_HIGH = 3'd2,
    REASON_GAP         = 3'd3,
    REASON_REORDER     = 3'd4
  } reason_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DIV,
    ST_SEND
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic capture;    // observe request taken this cycle
    logic load;       // snapshot statistics, start the average divide
    logic window;     // snapshot selects window statistics and clears them
    logic avg_latch;  // divide finished, store the average
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic div_done;
  } status_t;

  typedef struct packed {
    reason_t                    reason;
    logic [CNT_W-1:0]           life_samples;
    logic [CNT_W-1:0]           win_samples;
    logic signed [DELAY_W-1:0]  last_delay_ns;
    logic signed [DELAY_W-1:0]  average_delay_ns;
    logic [DMAX_W-1:0]          max_delay_ns;
    logic [STAMP_W-1:0]         last_period_ns;
    logic [CNT_W-1:0]           last_jitter_ns;
    logic [CNT_W-1:0]           max_jitter_ns;
    logic [CNT_W-1:0]           reordered_count;
    logic [CNT_W-1:0]           gap_count;
    logic [STAMP_W-1:0]         max_gap_ns;
  } result_t;

endpackage

[rtl/core/sthm_if.sv]
// request and result channel interfaces of the health monitor
// depends on sthm_pkg for field widths and the reason type
interface sthm_req_if;
  import sthm_pkg::*;
  logic                valid;
  logic                ready;
  logic [FUNC_W-1:0]   func;
  logic [STAMP_W-1:0]  hdr_time_ns;
  logic [STAMP_W-1:0]  rcv_time_ns;

  modport source (output valid, func, hdr_time_ns, rcv_time_ns, input ready);
  modport sink   (input valid, func, hdr_time_ns, rcv_time_ns, output ready);
endinterface

interface sthm_rsp_if;
  import sthm_pkg::*;
  logic                       valid;
  logic                       ready;
  logic [2:0]                 reason;
  logic [CNT_W-1:0]           life_samples;
  logic [CNT_W-1:0]           win_samples;
  logic signed [DELAY_W-1:0]  last_delay_ns;
  logic signed [DELAY_W-1:0]  average_delay_ns;
  logic [DMAX_W-1:0]          max_delay_ns;
  logic [STAMP_W-1:0]         last_period_ns;
  logic [CNT_W-1:0]           last_jitter_ns;
  logic [CNT_W-1:0]           max_jitter_ns;
  logic [CNT_W-1:0]           reordered_count;
  logic [CNT_W-1:0]           gap_count;
  logic [STAMP_W-1:0]         max_gap_ns;

  modport source (output valid, reason, life_samples, win_samples, last_delay_ns,
                  average_delay_ns, max_delay_ns, last_period_ns, last_jitter_ns,
                  max_jitter_ns, reordered_count, gap_count, max_gap_ns,
                  input ready);
  modport sink   (input valid, reason, life_samples, win_samples, last_delay_ns,
                  average_delay_ns, max_delay_ns, last_period_ns, last_jitter_ns,
                  max_jitter_ns, reordered_count, gap_count, max_gap_ns,
                  output ready);
endinterface

[rtl/core/sthm_div.sv]
// restoring divider, one quotient bit per cycle: 64-bit magnitude by 32-bit count
// depends on sthm_pkg for the sum and count widths
module sthm_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [sthm_pkg::SUM_W-1:0] dividend,
  input  logic [sthm_pkg::CNT_W-1:0] divisor,
  output logic [sthm_pkg::SUM_W-1:0] quotient,
  output logic                       done
);
  import sthm_pkg::*;

  localparam int STEP_W = $clog2(SUM_W);

  logic              busy;
  logic [STEP_W-1:0] step;
  logic [CNT_W-1:0]  rem;
  logic [CNT_W-1:0]  dvs;
  logic [SUM_W-1:0]  shreg;
  logic [CNT_W:0]    trial;
  logic              fits;

  // dividend bits leave the top of shreg while quotient bits enter the bottom
  always_comb begin
    trial = {rem, shreg[SUM_W-1]};
    fits  = trial >= {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == STEP_W'(SUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= '0;
      dvs   <= divisor;
      shreg <= dividend;
    end else if (busy) begin
      if (fits) begin
        rem <= CNT_W'(trial - {1'b0, dvs});
      end else begin
        rem <= trial[CNT_W-1:0];
      end
      shreg <= {shreg[SUM_W-2:0], fits};
    end
  end

  assign quotient = shreg;

endmodule

[rtl/core/sthm_datapath.sv]
// statistics datapath: observe pipeline, config registers, summary snapshot
// depends on sthm_pkg and instantiates sthm_div for the average
module sthm_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [sthm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sthm_pkg::CFG_W-1:0]    cfg_data,
  input  sthm_pkg::cmd_t                cmd,
  output sthm_pkg::status_t             status,
  input  logic [sthm_pkg::STAMP_W-1:0]  hdr_time_ns,
  input  logic [sthm_pkg::STAMP_W-1:0]  rcv_time_ns,
  output sthm_pkg::result_t             result
);
  import sthm_pkg::*;

  localparam logic [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};
  localparam logic [DELAY_W-1:0] D48_MAX = {1'b0, {(DELAY_W-1){1'b1}}};
  localparam logic [DELAY_W-1:0] D48_MIN = {1'b1, {(DELAY_W-1){1'b0}}};
  localparam int HI_W = SUM_W - DELAY_W + 1;

  function automatic logic [CNT_W-1:0] inc_sat(input logic [CNT_W-1:0] c);
    return (&c) ? c : c + 1'b1;
  endfunction

  // config registers
  logic [CFG_W-1:0] gap_threshold_ns;
  logic [CFG_W-1:0] jitter_warn_ns;
  logic [CFG_W-1:0] jitter_degrade_ns;

  // observe stage one
  logic               s1_valid;
  logic [DELAY_W-1:0] s1_delay;
  logic               s1_has_period;
  logic               s1_period_neg;
  logic [STAMP_W-1:0] s1_period;

  // statistics
  logic [STAMP_W-1:0] prev_stamp;
  logic               prev_stamp_valid;
  logic [CNT_W-1:0]   prev_period;
  logic               prev_period_valid;
  logic [CNT_W-1:0]   sample_total, sample_window;
  logic [SUM_W-1:0]   delay_sum_total, delay_sum_window;
  logic [DMAX_W-1:0]  delay_max_total, delay_max_window;
  logic [DELAY_W-1:0] delay_last;
  logic [STAMP_W-1:0] period_last;
  logic [CNT_W-1:0]   jitter_last, jitter_max_total, jitter_max_window;
  logic [CNT_W-1:0]   reorder_total, reorder_window;
  logic [CNT_W-1:0]   gaps_total, gaps_window;
  logic [STAMP_W-1:0] gap_max;

  // combinational helpers
  logic [SUM_W-1:0]   delay_diff;
  logic [SUM_W-1:0]   period_diff;
  logic [DELAY_W-1:0] delay_sat;
  logic [SUM_W-1:0]   d_ext;
  logic [SUM_W-1:0]   add_total, add_window;
  logic [SUM_W-1:0]   sum_total_next, sum_window_next;
  logic               delay_pos;
  logic               is_gap;
  logic [CNT_W-1:0]   pu;
  logic [CNT_W-1:0]   jitter;

  // snapshot selection
  logic [CNT_W-1:0]   sel_cnt, sel_jm, sel_ro, sel_gp;
  logic [SUM_W-1:0]   sel_sum;
  logic [DMAX_W-1:0]  sel_dm;
  reason_t            sel_reason;

  // average
  logic [SUM_W-1:0]   quotient;
  logic               avg_neg;
  logic               cnt_zero;
  logic [DELAY_W-1:0] avg_value;

  always_ff @(posedge clk) begin
    if (rst) begin
      gap_threshold_ns  <= GAP_THRESHOLD_RESET;
      jitter_warn_ns    <= JITTER_WARN_RESET;
      jitter_degrade_ns <= JITTER_DEGRADE_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_GAP_THRESHOLD:  gap_threshold_ns  <= cfg_data;
        CFG_JITTER_WARN:    jitter_warn_ns    <= cfg_data;
        CFG_JITTER_DEGRADE: jitter_degrade_ns <= cfg_data;
        default: ;
      endcase
    end
  end

  // stage one: delay and period differences
  always_comb begin
    delay_diff  = {1'b0, rcv_time_ns} - {1'b0, hdr_time_ns};
    period_diff = {1'b0, hdr_time_ns} - {1'b0, prev_stamp};
    if ((&delay_diff[SUM_W-1:DELAY_W-1]) || !(|delay_diff[SUM_W-1:DELAY_W-1])) begin
      delay_sat = delay_diff[DELAY_W-1:0];
    end else if (delay_diff[SUM_W-1]) begin
      delay_sat = D48_MIN;
    end else begin
      delay_sat = D48_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid         <= 1'b0;
      prev_stamp_valid <= 1'b0;
      prev_stamp       <= '0;
    end else begin
      s1_valid <= cmd.capture;
      if (cmd.capture) begin
        prev_stamp       <= hdr_time_ns;
        prev_stamp_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      s1_delay      <= delay_sat;
      s1_has_period <= prev_stamp_valid;
      s1_period_neg <= period_diff[SUM_W-1];
      s1_period     <= period_diff[STAMP_W-1:0];
    end
  end

  // stage two: saturating sums, maxima, period classification
  always_comb begin
    d_ext      = {{(SUM_W-DELAY_W){s1_delay[DELAY_W-1]}}, s1_delay};
    add_total  = delay_sum_total + d_ext;
    add_window = delay_sum_window + d_ext;
    if (delay_sum_total[SUM_W-1] == d_ext[SUM_W-1] &&
        add_total[SUM_W-1] != d_ext[SUM_W-1]) begin
      sum_total_next = d_ext[SUM_W-1] ? SUM_MIN : SUM_MAX;
    end else begin
      sum_total_next = add_total;
    end
    if (delay_sum_window[SUM_W-1] == d_ext[SUM_W-1] &&
        add_window[SUM_W-1] != d_ext[SUM_W-1]) begin
      sum_window_next = d_ext[SUM_W-1] ? SUM_MIN : SUM_MAX;
    end else begin
      sum_window_next = add_window;
    end
    delay_pos = !s1_delay[DELAY_W-1] && (|s1_delay);
    is_gap    = s1_period > {{(STAMP_W-CFG_W){1'b0}}, gap_threshold_ns};
    pu        = s1_period[CNT_W-1:0];
    jitter    = (pu >= prev_period) ? pu - prev_period : prev_period - pu;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_period       <= '0;
      prev_period_valid <= 1'b0;
      sample_total      <= '0;
      sample_window     <= '0;
      delay_sum_total   <= '0;
      delay_sum_window  <= '0;
      delay_max_total   <= '0;
      delay_max_window  <= '0;
      delay_last        <= '0;
      period_last       <= '0;
      jitter_last       <= '0;
      jitter_max_total  <= '0;
      jitter_max_window <= '0;
      reorder_total     <= '0;
      reorder_window    <= '0;
      gaps_total        <= '0;
      gaps_window       <= '0;
      gap_max           <= '0;
    end else begin
      if (s1_valid) begin
        delay_last       <= s1_delay;
        delay_sum_total  <= sum_total_next;
        delay_sum_window <= sum_window_next;
        if (delay_pos && s1_delay[DMAX_W-1:0] > delay_max_total) begin
          delay_max_total <= s1_delay[DMAX_W-1:0];
        end
        if (delay_pos && s1_delay[DMAX_W-1:0] > delay_max_window) begin
          delay_max_window <= s1_delay[DMAX_W-1:0];
        end
        sample_total  <= inc_sat(sample_total);
        sample_window <= inc_sat(sample_window);
        if (s1_has_period) begin
          if (s1_period_neg) begin
            reorder_total  <= inc_sat(reorder_total);
            reorder_window <= inc_sat(reorder_window);
          end else if (is_gap) begin
            gaps_total        <= inc_sat(gaps_total);
            gaps_window       <= inc_sat(gaps_window);
            period_last       <= s1_period;
            prev_period_valid <= 1'b0;
            if (s1_period > gap_max) begin
              gap_max <= s1_period;
            end
          end else begin
            period_last       <= s1_period;
            prev_period       <= pu;
            prev_period_valid <= 1'b1;
            if (prev_period_valid) begin
              jitter_last <= jitter;
              if (jitter > jitter_max_total) begin
                jitter_max_total <= jitter;
              end
              if (jitter > jitter_max_window) begin
                jitter_max_window <= jitter;
              end
            end
          end
        end
      end
      // window summary consumes the window
      if (cmd.load && cmd.window) begin
        sample_window     <= '0;
        delay_sum_window  <= '0;
        delay_max_window  <= '0;
        jitter_max_window <= '0;
        reorder_window    <= '0;
        gaps_window       <= '0;
      end
    end
  end

  // summary snapshot
  always_comb begin
    sel_cnt = cmd.window ? sample_window     : sample_total;
    sel_sum = cmd.window ? delay_sum_window  : delay_sum_total;
    sel_dm  = cmd.window ? delay_max_window  : delay_max_total;
    sel_jm  = cmd.window ? jitter_max_window : jitter_max_total;
    sel_ro  = cmd.window ? reorder_window    : reorder_total;
    sel_gp  = cmd.window ? gaps_window       : gaps_total;
    if (|sel_ro) begin
      sel_reason = REASON_REORDER;
    end else if (|sel_gp) begin
      sel_reason = REASON_GAP;
    end else if (sel_jm > jitter_degrade_ns) begin
      sel_reason = REASON_JITTER_HIGH;
    end else if (sel_jm > jitter_warn_ns) begin
      sel_reason = REASON_JITTER_WARN;
    end else begin
      sel_reason = REASON_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      result.reason          <= sel_reason;
      result.life_samples    <= sample_total;
      result.win_samples     <= sel_cnt;
      result.last_delay_ns   <= delay_last;
      result.max_delay_ns    <= sel_dm;
      result.last_period_ns  <= period_last;
      result.last_jitter_ns  <= jitter_last;
      result.max_jitter_ns   <= sel_jm;
      result.reordered_count <= sel_ro;
      result.gap_count       <= sel_gp;
      result.max_gap_ns      <= gap_max;
      avg_neg                <= sel_sum[SUM_W-1];
      cnt_zero               <= !(|sel_cnt);
    end
    if (cmd.avg_latch) begin
      result.average_delay_ns <= avg_value;
    end
  end

  sthm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.load),
    .dividend (sel_sum[SUM_W-1] ? (~sel_sum + 1'b1) : sel_sum),
    .divisor  (sel_cnt),
    .quotient (quotient),
    .done     (status.div_done)
  );

  // sign the magnitude quotient and clamp to 48 bits
  always_comb begin
    if (cnt_zero) begin
      avg_value = '0;
    end else if (!avg_neg) begin
      avg_value = (|quotient[SUM_W-1:DELAY_W-1]) ? D48_MAX : quotient[DELAY_W-1:0];
    end else if (quotient > {{(HI_W-1){1'b0}}, D48_MIN}) begin
      avg_value = D48_MIN;
    end else begin
      avg_value = ~quotient[DELAY_W-1:0] + 1'b1;
    end
  end

endmodule

[rtl/core/sthm_ctrl.sv]
// request sequencing: observe pass-through, summary snapshot, divide, result hold
// depends on sthm_pkg for the state, command and status types
module sthm_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       req_valid,
  input  logic [sthm_pkg::FUNC_W-1:0] req_func,
  output logic                       req_ready,
  output logic                       rsp_valid,
  input  logic                       rsp_ready,
  output sthm_pkg::cmd_t             cmd,
  input  sthm_pkg::status_t          status
);
  import sthm_pkg::*;

  state_t state, state_next;
  logic   window_sel, window_sel_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      window_sel <= 1'b0;
    end else begin
      state      <= state_next;
      window_sel <= window_sel_next;
    end
  end

  always_comb begin
    state_next      = state;
    window_sel_next = window_sel;
    req_ready       = 1'b0;
    rsp_valid       = 1'b0;
    cmd             = '0;
    cmd.window      = window_sel;
    case (state)
      ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          case (req_func)
            FUNC_OBSERVE: cmd.capture = 1'b1;
            FUNC_WINDOW: begin
              window_sel_next = 1'b1;
              state_next      = ST_LOAD;
            end
            FUNC_LIFETIME: begin
              window_sel_next = 1'b0;
              state_next      = ST_LOAD;
            end
            default: ;
          endcase
        end
      end
      ST_LOAD: begin
        cmd.load   = 1'b1;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        if (status.div_done) begin
          cmd.avg_latch = 1'b1;
          state_next    = ST_SEND;
        end
      end
      ST_SEND: begin
        rsp_valid = 1'b1;
        if (rsp_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

[rtl/core/sensor_timestamp_health_monitor.sv]
// sensor timestamp health monitor, top level
// depends on sthm_pkg, sthm_if, sthm_ctrl, sthm_datapath and sthm_div
//
// usage:
// - req channel carries one request: func, hdr_time_ns, rcv_time_ns
// - observe requests (func 0) are taken one per cycle while idle and give no result;
//   each passes the stage-one registers before it is applied to the statistics
// - window (func 1) and lifetime (func 2) summary requests each give one result
//   on the rsp channel; a window summary also clears the window statistics
// - func 3 is taken and dropped
// - a summary result is built after its request is taken: a snapshot of the
//   statistics, the bit-serial average divider, the clamp and store of the
//   average, after which the result register holds it
// - while a summary is in flight or its result waits, req.ready stays low,
//   so a stalled receiver holds the whole block; the result register keeps
//   the values stable until rsp.ready is seen
// - cfg_write with cfg_index 0..2 sets gap threshold, jitter warn, jitter
//   degrade; other indexes are ignored; write only while idle
// - synchronous reset clears all statistics and loads the default thresholds
module sensor_timestamp_health_monitor (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [sthm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sthm_pkg::CFG_W-1:0]     cfg_data,
  sthm_req_if.sink                       req,
  sthm_rsp_if.source                     rsp
);
  import sthm_pkg::*;

  cmd_t    cmd;
  status_t status;
  result_t result;

  sthm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_func  (req.func),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .cmd       (cmd),
    .status    (status)
  );

  sthm_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .cmd         (cmd),
    .status      (status),
    .hdr_time_ns (req.hdr_time_ns),
    .rcv_time_ns (req.rcv_time_ns),
    .result      (result)
  );

  // result register fans out to the channel fields
  assign rsp.reason           = result.reason;
  assign rsp.life_samples     = result.life_samples;
  assign rsp.win_samples      = result.win_samples;
  assign rsp.last_delay_ns    = result.last_delay_ns;
  assign rsp.average_delay_ns = result.average_delay_ns;
  assign rsp.max_delay_ns     = result.max_delay_ns;
  assign rsp.last_period_ns   = result.last_period_ns;
  assign rsp.last_jitter_ns   = result.last_jitter_ns;
  assign rsp.max_jitter_ns    = result.max_jitter_ns;
  assign rsp.reordered_count  = result.reordered_count;
  assign rsp.gap_count        = result.gap_count;
  assign rsp.max_gap_ns       = result.max_gap_ns;

  // a held result blocks new requests
  a_hold_blocks_req: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> !req.ready)
    else $error("request taken while a result waits");

  // a summary request never yields a result in the next cycle
  a_summary_latency: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready && (req.func == FUNC_WINDOW || req.func == FUNC_LIFETIME))
      |=> !rsp.valid)
    else $error("result shown before the average is done");

  // one result per summary
  a_single_result: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.ready) |=> !rsp.valid)
    else $error("result repeated");

  // divider finishes only while the controller waits for it
  a_div_done_state: assert property (@(posedge clk) disable iff (rst)
    status.div_done |-> (!req.ready && !rsp.valid))
    else $error("divider done outside of a summary");

endmodule
